// ===== hw/rtl/drre_pkg.sv =====
package drre_pkg;

    localparam int MAX_RECTS  = 16;
    localparam int RESULT_CAP = 16;
    localparam int IDX_W      = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W      = $clog2(MAX_RECTS + 1);
    localparam int RES_W      = $clog2(RESULT_CAP + 1);

    localparam logic signed [15:0] S16_HI = 16'sh7FFF;
    localparam logic signed [15:0] S16_LO = 16'sh8000;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_OFFSET = 3'd2,
        CMD_BBOX   = 3'd3,
        CMD_ISECT  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } t_rect;

    // running bounding box edges
    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] rt;
        logic signed [15:0] bt;
    } t_bbox;

endpackage

// ===== hw/rtl/drre_rect_ram.sv =====
module drre_rect_ram
    import drre_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_rect            i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_rect            o_rd_data
);

    t_rect r_mem [MAX_RECTS];
    t_rect r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/drre_alu.sv =====
module drre_alu
    import drre_pkg::*;
(
    input  t_rect              i_entry,
    input  t_rect              i_op,
    input  logic signed [15:0] i_shift_x,
    input  logic signed [15:0] i_shift_y,
    input  t_bbox              i_box,
    output t_rect              o_moved,
    output t_bbox              o_box,
    output t_rect              o_isect,
    output logic               o_isect_pos
);

    logic signed [16:0] b_right;
    logic signed [16:0] b_bottom;
    logic signed [16:0] a_right;
    logic signed [16:0] a_bottom;
    logic signed [16:0] min_right;
    logic signed [16:0] min_bottom;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] iw;
    logic signed [15:0] ih;

    // exact 17-bit edges
    assign b_right  = 17'(i_entry.x) + 17'(i_entry.w);
    assign b_bottom = 17'(i_entry.y) + 17'(i_entry.h);
    assign a_right  = 17'(i_op.x) + 17'(i_op.w);
    assign a_bottom = 17'(i_op.y) + 17'(i_op.h);

    // offset: wrap at 16 bits
    always_comb begin
        o_moved   = i_entry;
        o_moved.x = i_entry.x + i_shift_x;
        o_moved.y = i_entry.y + i_shift_y;
    end

    // bounding box: compare the exact edge against the truncated running edge
    always_comb begin
        o_box = i_box;
        if (i_entry.x < i_box.l) begin
            o_box.l = i_entry.x;
        end
        if (i_entry.y < i_box.t) begin
            o_box.t = i_entry.y;
        end
        if (b_right > 17'(i_box.rt)) begin
            o_box.rt = b_right[15:0];
        end
        if (b_bottom > 17'(i_box.bt)) begin
            o_box.bt = b_bottom[15:0];
        end
    end

    // intersection
    assign min_right  = (a_right < b_right) ? a_right : b_right;
    assign min_bottom = (a_bottom < b_bottom) ? a_bottom : b_bottom;
    assign left       = (i_op.x < i_entry.x) ? i_entry.x : i_op.x;
    assign top        = (i_op.y < i_entry.y) ? i_entry.y : i_op.y;
    assign iw         = min_right[15:0] - left;
    assign ih         = min_bottom[15:0] - top;

    assign o_isect     = '{x: left, y: top, w: iw, h: ih};
    assign o_isect_pos = (iw > 16'sd0) && (ih > 16'sd0);

endmodule

// ===== hw/rtl/dirty_rect_region_engine.sv =====
// Dirty-rectangle list engine. Holds up to MAX_RECTS rectangles in a small
// RAM with a registered read port and runs one command per input item, taken
// only while the engine is idle (o_s_axis_tready high). Add, clear and
// unknown commands pass from accept through ST_FINISH to the output register.
// Offset, bounding box and intersect walk the list through the single RAM
// read port and a shared per-entry arithmetic unit, one stored rectangle per
// cycle, then pass through ST_FINISH (an empty list skips the walk); an
// intersect additionally waits whenever a finished overlap cannot be handed
// to the output register, and every command holds in ST_FINISH while the
// output register still carries an untaken item.
// Intersect delivers every positive-area overlap in list order, the final one
// with tlast, or one empty result; at most RESULT_CAP results per command.
// Every other command yields exactly one result with tlast. The output
// register lets the engine go back to idle while the last result waits.
module dirty_rect_region_engine
    import drre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] rect_x, [31:16] rect_y, [47:32] rect_w, [63:48] rect_h,
    // [79:64] shift_x, [95:80] shift_y
    input  logic [95:0] i_s_axis_tdata,
    // [2:0] cmd
    input  logic [2:0]  i_s_axis_tuser,
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] out_x, [31:16] out_y, [47:32] out_w, [63:48] out_h,
    // [68:64] stored_count, [71:69] zero
    output logic [71:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // [0] has_rect, [1] dropped
    output logic [1:0]  o_m_axis_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;

    // command and operands
    logic [2:0]         r_cmd, n_cmd;
    t_rect              r_op, n_op;
    logic signed [15:0] r_sx, n_sx;
    logic signed [15:0] r_sy, n_sy;
    logic               r_drop, n_drop;

    // list and walk state
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [RES_W-1:0]   r_nres, n_nres;
    t_bbox              r_box, n_box;
    t_rect              r_pend, n_pend;
    logic               r_pend_valid, n_pend_valid;

    // output register
    logic               r_out_valid, n_out_valid;
    t_rect              r_out, n_out;
    logic               r_out_has, n_out_has;
    logic               r_out_last, n_out_last;
    logic               r_out_drop, n_out_drop;
    logic [4:0]         r_out_cnt, n_out_cnt;

    // RAM port
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    t_rect              ram_wr_data;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    t_rect              ram_rd_data;

    // shared unit
    t_rect              alu_moved;
    t_bbox              alu_box;
    t_rect              alu_isect;
    logic               alu_pos;

    t_rect              in_rect;
    logic [2:0]         in_cmd;
    logic               out_free;
    logic               walk_cmd;
    logic               stall;
    logic               last_step;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W+4:0]   cnt_ext;

    assign in_cmd  = i_s_axis_tuser;
    assign in_rect = '{x: i_s_axis_tdata[15:0],  y: i_s_axis_tdata[31:16],
                       w: i_s_axis_tdata[47:32], h: i_s_axis_tdata[63:48]};

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign idx_next = r_idx + 1'b1;
    assign cnt_ext  = {5'b0, r_count};

    drre_rect_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    drre_alu u_alu (
        .i_entry     (ram_rd_data),
        .i_op        (r_op),
        .i_shift_x   (r_sx),
        .i_shift_y   (r_sy),
        .i_box       (r_box),
        .o_moved     (alu_moved),
        .o_box       (alu_box),
        .o_isect     (alu_isect),
        .o_isect_pos (alu_pos)
    );

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_op         = r_op;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_drop       = r_drop;
        n_count      = r_count;
        n_idx        = r_idx;
        n_nres       = r_nres;
        n_box        = r_box;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_out_has    = r_out_has;
        n_out_last   = r_out_last;
        n_out_drop   = r_out_drop;
        n_out_cnt    = r_out_cnt;

        ram_wr_en   = 1'b0;
        ram_wr_addr = r_count[IDX_W-1:0];
        ram_wr_data = in_rect;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx[IDX_W-1:0];

        walk_cmd  = 1'b0;
        stall     = 1'b0;
        last_step = 1'b0;

        // drop the output item once taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_cmd        = in_cmd;
                    n_op         = in_rect;
                    n_sx         = i_s_axis_tdata[79:64];
                    n_sy         = i_s_axis_tdata[95:80];
                    n_drop       = 1'b0;
                    n_idx        = '0;
                    n_nres       = '0;
                    n_pend_valid = 1'b0;
                    n_box        = '{l: S16_HI, t: S16_HI,
                                     rt: S16_LO, bt: S16_LO};
                    walk_cmd     = (in_cmd == CMD_OFFSET) || (in_cmd == CMD_BBOX) ||
                                   (in_cmd == CMD_ISECT);
                    if (in_cmd == CMD_ADD) begin
                        if (r_count < CNT_W'(MAX_RECTS)) begin
                            ram_wr_en = 1'b1;
                            n_count   = r_count + 1'b1;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    if (in_cmd == CMD_CLEAR) begin
                        n_count = '0;
                    end
                    if (walk_cmd && (r_count != '0)) begin
                        // fetch the first entry
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        n_state     = ST_WALK;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end

            ST_WALK: begin
                // hold when a finished overlap has nowhere to go
                stall = (r_cmd == CMD_ISECT) && alu_pos && r_pend_valid && !out_free;
                if (!stall) begin
                    if (r_cmd == CMD_OFFSET) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = r_idx[IDX_W-1:0];
                        ram_wr_data = alu_moved;
                    end
                    if (r_cmd == CMD_BBOX) begin
                        n_box = alu_box;
                    end
                    if ((r_cmd == CMD_ISECT) && alu_pos) begin
                        // push the previous overlap out, keep the new one back
                        // until we know whether it is the final one
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                            n_out_has   = 1'b1;
                            n_out_last  = 1'b0;
                            n_out_drop  = 1'b0;
                            n_out_cnt   = cnt_ext[4:0];
                        end
                        n_pend       = alu_isect;
                        n_pend_valid = 1'b1;
                        n_nres       = r_nres + 1'b1;
                    end
                    last_step = (idx_next == r_count) ||
                                ((r_cmd == CMD_ISECT) && alu_pos &&
                                 (r_nres == RES_W'(RESULT_CAP - 1)));
                    if (last_step) begin
                        n_state = ST_FINISH;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_next[IDX_W-1:0];
                        n_idx       = idx_next;
                    end
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_out_drop   = r_drop;
                    n_out_cnt    = cnt_ext[4:0];
                    n_out_has    = 1'b0;
                    n_out        = '0;
                    if ((r_cmd == CMD_BBOX) && (r_count != '0)) begin
                        n_out_has = 1'b1;
                        n_out     = '{x: r_box.l, y: r_box.t,
                                      w: r_box.rt - r_box.l, h: r_box.bt - r_box.t};
                    end
                    if ((r_cmd == CMD_ISECT) && r_pend_valid) begin
                        n_out_has = 1'b1;
                        n_out     = r_pend;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_nres       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cmd        <= '0;
            r_drop       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_nres       <= n_nres;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_cmd        <= n_cmd;
            r_drop       <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_box      <= n_box;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
        r_out_drop <= n_out_drop;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_cnt, r_out.h, r_out.w, r_out.y, r_out.x};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = {r_out_drop, r_out_has};

    // list never grows past its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECTS))
        else $error("rect count exceeds capacity");

    // a held-back overlap only exists during an intersect
    a_pend_isect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_cmd == CMD_ISECT))
        else $error("pending overlap outside intersect");

    // the list walk never starts on an empty list
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_count != '0) && (r_idx < r_count))
        else $error("walk index out of range");

    // ready is low in the cycle after an accepted item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready stayed high after accept");

endmodule
